/* hw/rtl/cpba_pkg.sv */
// ============================================================================
// cpba_pkg: shared types and constants for the contiguous page allocator
// Holds the field widths, the command and status codes and the control
// state type used by the allocator.
// ============================================================================
package cpba_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 1;
    localparam int PAGE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;

    // Value of the managed page count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd2;

    // Control states of the allocator.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL
    } t_state;

endpackage

/* hw/rtl/cpba_page_map.sv */
// ============================================================================
// cpba_page_map: one-bit-per-page usage memory
// A single-bit-wide memory with one write port and one read port; the read
// data is registered and appears in the cycle after the address.
// ============================================================================
module cpba_page_map #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/contiguous_page_bitmap_allocator.sv */
// ============================================================================
// contiguous_page_bitmap_allocator: first-fit contiguous page allocator
// Keeps a used bit per page and serves allocate and free requests for runs
// of consecutive pages, scanning and updating the map one page per cycle.
//
//   Channel   Signals                                      Direction
//   request   start, busy, i_cmd, i_start_page,            in (busy out)
//             i_page_count
//   result    o_done, o_status, o_first_page               out
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data         in (ready out)
//
// A bad request answers in the cycle after it is taken. A free clears
// its page_count pages through the page map write port. An allocate
// scans the map bit by bit through the page map read port, then marks
// the run it found through the map's single write port.
// After reset the page map is cleared one page per cycle, all PAGE_SLOTS
// pages, while busy is high. Results are strobed for one cycle on o_done;
// the receiver cannot stall them. The page count register is taken only
// while idle with no item offered.
// ============================================================================
module contiguous_page_bitmap_allocator #(
    parameter int PAGE_SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cpba_pkg::CMD_W-1:0]    i_cmd,
    input  logic [cpba_pkg::PAGE_W-1:0]   i_start_page,
    input  logic [cpba_pkg::COUNT_W-1:0]  i_page_count,
    output logic                          o_done,
    output logic [cpba_pkg::STATUS_W-1:0] o_status,
    output logic [cpba_pkg::PAGE_W-1:0]   o_first_page,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpba_pkg::CFG_W-1:0]    i_cfg_data
);

    import cpba_pkg::*;

    // Page index width, pointer width (holds PAGE_SLOTS) and compare width.
    localparam int PW = $clog2(PAGE_SLOTS);
    localparam int CW = PW + 1;
    localparam int LW = (CW > 10) ? CW : 10;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_pages_in_use;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic                 r_chk_vld, n_chk_vld;
    logic [PW-1:0]        r_chk_page, n_chk_page;
    logic [COUNT_W-1:0]   r_run, n_run;
    logic [PW-1:0]        r_run_start, n_run_start;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [PW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic                 r_wr_val, n_wr_val;
    logic                 r_done, n_done;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [PAGE_W-1:0]    r_first, n_first;

    logic                 map_we;
    logic                 map_wd;
    logic [PW-1:0]        map_wa;
    logic [PW-1:0]        map_ra;
    logic                 map_rd;

    logic [LW-1:0]        w_cfg_ext;
    logic [LW-1:0]        w_limit;
    logic [LW-1:0]        w_cnt_ext;
    logic [LW-1:0]        w_end_ext;
    logic                 w_bad;
    logic [PW-1:0]        w_start_now;

    cpba_page_map #(
        .DEPTH (PAGE_SLOTS),
        .AW    (PW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_wa),
        .i_wdata (map_wd),
        .i_raddr (map_ra),
        .o_rdata (map_rd)
    );

    // Managed page count, saturated to the size of the map.
    assign w_cfg_ext = LW'(r_pages_in_use);
    assign w_limit   = (w_cfg_ext > LW'(PAGE_SLOTS)) ? LW'(PAGE_SLOTS) : w_cfg_ext;

    // Request checks on the incoming item.
    assign w_cnt_ext = LW'(i_page_count);
    assign w_end_ext = LW'(i_start_page) + LW'(i_page_count);
    assign w_bad     = (i_page_count == '0) ||
                       ((i_cmd == CMD_ALLOC) ? (w_cnt_ext > w_limit)
                                             : (w_end_ext > w_limit));

    // Start of the current free run if the page under test extends it.
    assign w_start_now = (r_run == '0) ? r_chk_page : r_run_start;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_wr_ptr       <= '0;
            r_done         <= 1'b0;
            r_chk_vld      <= 1'b0;
            r_pages_in_use <= CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_done    <= n_done;
            r_chk_vld <= n_chk_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pages_in_use <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_chk_page  <= n_chk_page;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_count     <= n_count;
        r_left      <= n_left;
        r_wr_val    <= n_wr_val;
        r_status    <= n_status;
        r_first     <= n_first;
    end

    // Next state, map access and result.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_chk_vld   = r_chk_vld;
        n_chk_page  = r_chk_page;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_count     = r_count;
        n_wr_ptr    = r_wr_ptr;
        n_left      = r_left;
        n_wr_val    = r_wr_val;
        n_done      = 1'b0;
        n_status    = r_status;
        n_first     = r_first;
        map_we      = 1'b0;
        map_wa      = r_wr_ptr;
        map_wd      = r_wr_val;
        map_ra      = r_ptr[PW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the whole map to free after reset.
                map_we   = 1'b1;
                map_wd   = 1'b0;
                n_wr_ptr = r_wr_ptr + 1'b1;
                if (r_wr_ptr == PW'(PAGE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (w_bad) begin
                        n_status = STAT_BAD;
                        n_first  = '0;
                        n_done   = 1'b1;
                    end else if (i_cmd == CMD_ALLOC) begin
                        n_state   = S_SCAN;
                        n_ptr     = '0;
                        n_chk_vld = 1'b0;
                        n_run     = '0;
                        n_count   = i_page_count;
                    end else begin
                        n_state  = S_FILL;
                        n_wr_ptr = PW'(i_start_page);
                        n_left   = i_page_count;
                        n_wr_val = 1'b0;
                        n_status = STAT_OK;
                        n_first  = '0;
                    end
                end
            end
            S_SCAN: begin
                // Issue the next read while pages remain.
                if (LW'(r_ptr) < w_limit) begin
                    n_ptr      = r_ptr + 1'b1;
                    n_chk_vld  = 1'b1;
                    n_chk_page = r_ptr[PW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                // Test the page whose bit has come back.
                if (r_chk_vld) begin
                    if (map_rd) begin
                        n_run = '0;
                    end else begin
                        n_run       = r_run + 1'b1;
                        n_run_start = w_start_now;
                        if ((r_run + 1'b1) == r_count) begin
                            n_state  = S_FILL;
                            n_wr_ptr = w_start_now;
                            n_left   = r_count;
                            n_wr_val = 1'b1;
                            n_status = STAT_OK;
                            n_first  = PAGE_W'(w_start_now);
                        end
                    end
                end else if (LW'(r_ptr) >= w_limit) begin
                    n_state  = S_IDLE;
                    n_status = STAT_NO_SPACE;
                    n_first  = '0;
                    n_done   = 1'b1;
                end
            end
            S_FILL: begin
                // Mark or clear one page of the run per cycle.
                map_we   = 1'b1;
                n_wr_ptr = r_wr_ptr + 1'b1;
                n_left   = r_left - 1'b1;
                if (r_left == COUNT_W'(1)) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_first_page = r_first;
    assign o_cfg_ready  = (r_state == S_IDLE) && !start;

    // A result other than ok never carries a page.
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == STAT_OK || o_first_page == '0))
        else $error("first page set on a failed result");

    // An accepted item either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item dropped");

    // The run writer never runs with nothing left to write.
    a_fill_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_left != '0))
        else $error("run write with zero pages left");

    // A result strobe never comes while clearing, scanning or writing a run.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result while the block is busy");

endmodule
